@@ src/esbc_pkg.sv @@
// ----------------------------------------------------------------------------
// esbc_pkg
// Shared types, constants and small tables for the epoch to BCD calendar unit.
// ----------------------------------------------------------------------------
package esbc_pkg;

    localparam int EPOCH_W  = 32;
    localparam int TZ_W     = 18;
    localparam int DAYS_W   = 16;
    localparam int SOD_W    = 17;   // seconds of day
    localparam int MSEC_W   = 12;   // seconds of hour
    localparam int WQ_W     = 13;   // whole weeks

    localparam logic [SOD_W-1:0]  SECS_PER_DAY  = 17'd86400;
    localparam logic [MSEC_W-1:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]        SECS_PER_MIN  = 6'd60;
    localparam logic [2:0]        DAYS_PER_WEEK = 3'd7;

    // floor(x / d) = (x * ceil(2^s / d)) >> s over each operand range
    // days use (t >> 7) / 675 since 86400 = 128 * 675
    localparam int          DAY_PRE_SH    = 7;
    localparam logic [25:0] RECIP_DAY     = 26'd50903317;
    localparam int          RECIP_DAY_SH  = 35;
    localparam logic [16:0] RECIP_WEEK    = 17'd74899;
    localparam int          RECIP_WEEK_SH = 19;
    localparam logic [17:0] RECIP_HOUR    = 18'd149131;
    localparam int          RECIP_HOUR_SH = 29;
    localparam logic [12:0] RECIP_MIN     = 13'd4370;
    localparam int          RECIP_MIN_SH  = 18;

    localparam logic signed [TZ_W-1:0] TZ_RESET = 18'sd19800;

    localparam logic [2:0] BASE_WEEKDAY = 3'd4;
    localparam logic [3:0] BASE_TENS    = 4'd7;
    localparam logic [3:0] BASE_UNITS   = 4'd0;
    localparam logic [1:0] BASE_CENT    = 2'd0;   // 0 = 19xx, 1 = 20xx, 2 = 21xx
    localparam logic [1:0] BASE_Y4      = 2'd2;   // 1970 mod 4
    localparam logic [1:0] CENT_2000    = 2'd1;
    localparam logic [3:0] MONTH_LAST   = 4'd11;

    typedef struct packed {
        logic load;
        logic day_quo;
        logic day_rem;
        logic hour_quo;
        logic hour_rem;
        logic min_quo;
        logic min_rem;
        logic year_step;
        logic month_step;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_status;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // two packed bcd digits of a value below 64
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [5:0] tens;
        logic [5:0] units;
        tens = 6'd0;
        for (int k = 1; k <= 6; k++) begin
            if (v >= 6'(k * 10)) begin
                tens = 6'(k);
            end
        end
        units = v - 6'(tens * 6'd10);
        return {tens[3:0], units[3:0]};
    endfunction

endpackage

@@ src/esbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// esbc_ctrl
// Sequencer: three divisions, year walk, month walk, then output register load.
// ----------------------------------------------------------------------------
module esbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  esbc_pkg::t_status i_status,
    output esbc_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DQUO  = 4'd1;
    localparam logic [3:0] S_DREM  = 4'd2;
    localparam logic [3:0] S_HQUO  = 4'd3;
    localparam logic [3:0] S_HREM  = 4'd4;
    localparam logic [3:0] S_MQUO  = 4'd5;
    localparam logic [3:0] S_MREM  = 4'd6;
    localparam logic [3:0] S_YEAR  = 4'd7;
    localparam logic [3:0] S_MONTH = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DQUO;
                end
            end
            S_DQUO: begin
                o_cmd.day_quo = 1'b1;
                n_state       = S_DREM;
            end
            S_DREM: begin
                o_cmd.day_rem = 1'b1;
                n_state       = S_HQUO;
            end
            S_HQUO: begin
                o_cmd.hour_quo = 1'b1;
                n_state        = S_HREM;
            end
            S_HREM: begin
                o_cmd.hour_rem = 1'b1;
                n_state        = S_MQUO;
            end
            S_MQUO: begin
                o_cmd.min_quo = 1'b1;
                n_state       = S_MREM;
            end
            S_MREM: begin
                o_cmd.min_rem = 1'b1;
                n_state       = S_YEAR;
            end
            S_YEAR: begin
                if (!i_status.year_done) begin
                    o_cmd.year_step = 1'b1;
                end else begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (!i_status.month_done) begin
                    o_cmd.month_step = 1'b1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output slot to drain
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ src/esbc_dp.sv @@
// ----------------------------------------------------------------------------
// esbc_dp
// Datapath: offset add, reciprocal dividers, year and month walkers,
// bcd conversion and output registers.
// ----------------------------------------------------------------------------
module esbc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  esbc_pkg::t_cmd                      i_cmd,
    output esbc_pkg::t_status                   o_status,
    input  logic                                i_cfg_valid,
    input  logic signed [esbc_pkg::TZ_W-1:0]    i_cfg_time_zone_offset,
    input  logic [esbc_pkg::EPOCH_W-1:0]        i_epoch_seconds,
    output logic [7:0]                          o_year_bcd,
    output logic [4:0]                          o_month_bcd,
    output logic [5:0]                          o_day_bcd,
    output logic [2:0]                          o_weekday,
    output logic [5:0]                          o_hour_bcd,
    output logic [6:0]                          o_minute_bcd,
    output logic [6:0]                          o_second_bcd,
    output logic                                o_range_error
);

    logic signed [esbc_pkg::TZ_W-1:0]   r_tz;
    logic [esbc_pkg::EPOCH_W-1:0]       r_t;
    logic [esbc_pkg::SOD_W-1:0]         r_sod;
    logic [esbc_pkg::MSEC_W-1:0]        r_msec;
    logic [esbc_pkg::WQ_W-1:0]          r_wq;
    logic [2:0]                         r_wd;
    logic [esbc_pkg::DAYS_W-1:0]        r_days;
    logic [4:0]                         r_hour;
    logic [5:0]                         r_minute;
    logic [5:0]                         r_second;
    logic [3:0]                         r_tens;
    logic [3:0]                         r_units;
    logic [1:0]                         r_cent;
    logic [1:0]                         r_y4;
    logic [3:0]                         r_mon;

    logic [50:0]                        day_prod;
    logic [32:0]                        week_prod;
    logic [34:0]                        hour_prod;
    logic [24:0]                        min_prod;
    logic [esbc_pkg::EPOCH_W-1:0]       day_base;
    logic [esbc_pkg::DAYS_W-1:0]        week_base;
    logic [esbc_pkg::SOD_W-1:0]         hour_base;
    logic [esbc_pkg::MSEC_W-1:0]        min_base;
    logic [2:0]                         wd_raw;
    logic [3:0]                         wd_sum;
    logic [2:0]                         wd_final;
    logic [esbc_pkg::EPOCH_W-1:0]       local_t;
    logic                               leap;
    logic [8:0]                         ylen;
    logic [4:0]                         mlen;
    logic                               range_bad;

    // quotients by reciprocal multiply, each remainder in the state after its quotient
    assign day_prod  = 51'(r_t[esbc_pkg::EPOCH_W-1:esbc_pkg::DAY_PRE_SH])
                     * 51'(esbc_pkg::RECIP_DAY);
    assign week_prod = 33'(r_days) * 33'(esbc_pkg::RECIP_WEEK);
    assign hour_prod = 35'(r_sod) * 35'(esbc_pkg::RECIP_HOUR);
    assign min_prod  = 25'(r_msec) * 25'(esbc_pkg::RECIP_MIN);

    assign day_base  = 32'(r_days) * 32'(esbc_pkg::SECS_PER_DAY);
    assign week_base = 16'(r_wq) * 16'(esbc_pkg::DAYS_PER_WEEK);
    assign hour_base = 17'(r_hour) * 17'(esbc_pkg::SECS_PER_HOUR);
    assign min_base  = 12'(r_minute) * 12'(esbc_pkg::SECS_PER_MIN);

    assign wd_raw   = 3'(r_days - week_base);
    assign wd_sum   = {1'b0, r_wd} + {1'b0, esbc_pkg::BASE_WEEKDAY};
    assign wd_final = (wd_sum >= {1'b0, esbc_pkg::DAYS_PER_WEEK})
                    ? 3'(wd_sum - {1'b0, esbc_pkg::DAYS_PER_WEEK}) : wd_sum[2:0];

    assign local_t = i_epoch_seconds
                   + {{(esbc_pkg::EPOCH_W - esbc_pkg::TZ_W){r_tz[esbc_pkg::TZ_W-1]}}, r_tz};

    // century years are leap only for 2000
    assign leap = (r_y4 == 2'd0)
                && ((r_tens != 4'd0) || (r_units != 4'd0) || (r_cent == esbc_pkg::CENT_2000));
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = esbc_pkg::month_len(r_mon, leap);
    assign range_bad = (r_tens == 4'd0) && (r_units < 4'd4);

    assign o_status.year_done  = (r_days < {7'd0, ylen});
    assign o_status.month_done = (r_mon == esbc_pkg::MONTH_LAST)
                               || (r_days < {11'd0, mlen});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz <= esbc_pkg::TZ_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_tz <= i_cfg_time_zone_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t     <= local_t;
            r_tens  <= esbc_pkg::BASE_TENS;
            r_units <= esbc_pkg::BASE_UNITS;
            r_cent  <= esbc_pkg::BASE_CENT;
            r_y4    <= esbc_pkg::BASE_Y4;
            r_mon   <= '0;
        end
        if (i_cmd.day_quo) begin
            r_days <= 16'(day_prod >> esbc_pkg::RECIP_DAY_SH);
        end
        if (i_cmd.day_rem) begin
            r_sod <= 17'(r_t - day_base);
            r_wq  <= 13'(week_prod >> esbc_pkg::RECIP_WEEK_SH);
        end
        if (i_cmd.hour_quo) begin
            r_hour <= 5'(hour_prod >> esbc_pkg::RECIP_HOUR_SH);
            r_wd   <= wd_raw;
        end
        if (i_cmd.hour_rem) begin
            r_msec <= 12'(r_sod - hour_base);
            r_wd   <= wd_final;
        end
        if (i_cmd.min_quo) begin
            r_minute <= 6'(min_prod >> esbc_pkg::RECIP_MIN_SH);
        end
        if (i_cmd.min_rem) begin
            r_second <= 6'(r_msec - min_base);
        end
        if (i_cmd.year_step) begin
            r_days <= r_days - {7'd0, ylen};
            r_y4   <= r_y4 + 2'd1;
            if (r_units == 4'd9) begin
                r_units <= 4'd0;
                if (r_tens == 4'd9) begin
                    r_tens <= 4'd0;
                    r_cent <= r_cent + 2'd1;
                end else begin
                    r_tens <= r_tens + 4'd1;
                end
            end else begin
                r_units <= r_units + 4'd1;
            end
        end
        if (i_cmd.month_step) begin
            r_days <= r_days - {11'd0, mlen};
            r_mon  <= r_mon + 4'd1;
        end
        if (i_cmd.publish) begin
            o_year_bcd    <= {r_tens, r_units};
            o_month_bcd   <= 5'(esbc_pkg::to_bcd({2'd0, r_mon} + 6'd1));
            o_day_bcd     <= 6'(esbc_pkg::to_bcd({1'b0, r_days[4:0]} + 6'd1));
            o_weekday     <= r_wd;
            o_hour_bcd    <= 6'(esbc_pkg::to_bcd({1'b0, r_hour}));
            o_minute_bcd  <= 7'(esbc_pkg::to_bcd(r_minute));
            o_second_bcd  <= 7'(esbc_pkg::to_bcd(r_second));
            o_range_error <= range_bad;
        end
    end

endmodule

@@ src/epoch_seconds_to_bcd_calendar_unit.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_bcd_calendar_unit
// Converts seconds since 1970 plus a time-zone offset into packed bcd date,
// time of day and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_in_valid / o_in_ready carries i_epoch_seconds
//   output channel o_out_valid / i_out_ready carries the bcd calendar fields
//   config channel i_cfg_valid / o_cfg_ready writes the signed offset and is
//   always ready; user must write it only while idle, which is not enforced
// Sequence: load, reciprocal division (quotient then remainder for days,
//   hours and minutes, weekday alongside), a walk over the years from
//   1970, a walk over the months, then the output load; the time per item
//   is set mostly by the year walker.
// One item is in work at a time; the next transfer is taken once the
//   previous result has moved to the output register, so an item can be
//   in work while an earlier result waits there.
// If the receiver stalls, the finished item waits in the sequencer until
//   the output register frees up; no input is taken meanwhile.
// Reset clears the sequencer and output valid and restores the offset
//   to +19800 seconds.
// ----------------------------------------------------------------------------
module epoch_seconds_to_bcd_calendar_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [esbc_pkg::EPOCH_W-1:0]        i_epoch_seconds,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_year_bcd,
    output logic [4:0]                          o_month_bcd,
    output logic [5:0]                          o_day_bcd,
    output logic [2:0]                          o_weekday,
    output logic [5:0]                          o_hour_bcd,
    output logic [6:0]                          o_minute_bcd,
    output logic [6:0]                          o_second_bcd,
    output logic                                o_range_error,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic signed [esbc_pkg::TZ_W-1:0]    i_cfg_time_zone_offset
);

    esbc_pkg::t_cmd    cmd;
    esbc_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    esbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    esbc_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_status               (status),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_time_zone_offset (i_cfg_time_zone_offset),
        .i_epoch_seconds        (i_epoch_seconds),
        .o_year_bcd             (o_year_bcd),
        .o_month_bcd            (o_month_bcd),
        .o_day_bcd              (o_day_bcd),
        .o_weekday              (o_weekday),
        .o_hour_bcd             (o_hour_bcd),
        .o_minute_bcd           (o_minute_bcd),
        .o_second_bcd           (o_second_bcd),
        .o_range_error          (o_range_error)
    );

`ifndef SYNTHESIS
    a_publish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over an untaken output");

    a_publish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |=> o_out_valid)
        else $error("output valid missing after result load");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_year_bcd)))
        else $error("output dropped or changed while stalled");
`endif

endmodule
